FILE: rtl/hmm_pkg.sv
// ----------------------------------------------------------------------------
// hmm_pkg
// shared types and constants of the hash multimap
// ----------------------------------------------------------------------------
`default_nettype none
package hmm_pkg;
    localparam int ENTRIES_DEF = 64;
    localparam int BUCKETS_DEF = 101;
    localparam int DATA_W      = 32;
    localparam int TOTAL_W     = 7;

    typedef enum logic [2:0] {
        CMD_ADD    = 3'd0,
        CMD_LOOKUP = 3'd1,
        CMD_REMOVE = 3'd2,
        CMD_MOST   = 3'd3,
        CMD_COUNT  = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef struct packed {
        logic [DATA_W-1:0] key;
        logic [DATA_W-1:0] value;
        logic [DATA_W-1:0] pstamp;
        logic [DATA_W-1:0] nstamp;
    } t_slot;

    typedef enum logic [4:0] {
        S_IDLE, S_ADD_RD, S_ADD_EV, S_ADD_WR,
        S_LK_RD, S_LK_EV, S_LK_END,
        S_RM_RD, S_RM_EV, S_RM_END,
        S_MF_RDI, S_MF_LATI, S_MF_RDJ, S_MF_EVJ, S_MF_DIV, S_MF_CMP, S_MF_END,
        S_OUT
    } t_state;
endpackage
`default_nettype wire

FILE: rtl/hash_multimap_with_top_key.sv
// ----------------------------------------------------------------------------
// hash_multimap_with_top_key
// bounded multimap of (key, value) pairs with a most-frequent-key query
// ----------------------------------------------------------------------------
// One command is taken at a time; o_stall stays high from acceptance until
// the last result word has been taken. All scans go through one slot memory
// read port. Lookup runs one full scan per returned value. Most frequent runs
// an outer scan and, for each stored slot, an inner counting scan plus a
// remainder for the bucket (one byte per step). Result words are held in an
// output register until taken.
`default_nettype none
module hash_multimap_with_top_key #(
    parameter int ENTRIES = hmm_pkg::ENTRIES_DEF,
    parameter int BUCKETS = hmm_pkg::BUCKETS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_stall,
    input  wire logic [2:0]                         i_command,
    input  wire logic signed [hmm_pkg::DATA_W-1:0]  i_key,
    input  wire logic signed [hmm_pkg::DATA_W-1:0]  i_value,
    output logic                                    o_valid,
    input  wire logic                               i_stall,
    output logic [1:0]                              o_status,
    output logic signed [hmm_pkg::DATA_W-1:0]       o_out_value,
    output logic signed [hmm_pkg::DATA_W-1:0]       o_out_key,
    output logic [hmm_pkg::TOTAL_W-1:0]             o_pair_total,
    output logic                                    o_is_empty,
    output logic                                    o_last
);
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int BW = $clog2(BUCKETS + 1);
    localparam int DW = hmm_pkg::DATA_W;

    hmm_pkg::t_state r_state, n_state, r_resume, n_resume;

    // command word
    logic [DW-1:0] r_key, n_key, r_val, n_val;
    // global state
    logic [DW-1:0] r_oc, n_oc;
    logic [CW-1:0] r_count, n_count;
    // scan indexes
    logic [IW-1:0] r_idx, n_idx, r_jdx, n_jdx;
    // add bookkeeping
    logic          r_free_f, n_free_f, r_own_f, n_own_f;
    logic [IW-1:0] r_free, n_free;
    logic [DW-1:0] r_own_ns, n_own_ns;
    // lookup / remove best so far
    logic          r_best_f, n_best_f, r_bound_en, n_bound_en;
    logic [IW-1:0] r_best, n_best;
    logic [DW-1:0] r_best_age, n_best_age, r_bound, n_bound, r_bval, n_bval;
    logic [CW-1:0] r_cand, n_cand;
    // most frequent
    logic [DW-1:0] r_ikey, n_ikey, r_ins, n_ins, r_bkey, n_bkey;
    logic [CW-1:0] r_icnt, n_icnt, r_bcnt, n_bcnt;
    logic [BW-1:0] r_bbkt, n_bbkt;
    // result register
    logic          r_ovalid, n_ovalid, r_olast, n_olast;
    logic [1:0]    r_status, n_status;
    logic [DW-1:0] r_oval, n_oval, r_okey, n_okey;

    // memory and remainder unit hookup
    logic [IW-1:0]   rd_addr;
    hmm_pkg::t_slot  rd_slot, wr_slot;
    logic            rd_valid, wr_en, clr_en, div_start, div_busy;
    logic [BW-1:0]   div_rem;
    logic [DW-1:0]   age, nage, div_mag;
    logic            key_hit, better;

    hmm_store #(.ENTRIES(ENTRIES)) u_store (
        .i_clk, .i_rst_n,
        .i_rd_addr(rd_addr), .o_rd_slot(rd_slot), .o_rd_valid(rd_valid),
        .i_wr_en(wr_en), .i_wr_addr(r_free), .i_wr_slot(wr_slot),
        .i_clr_en(clr_en), .i_clr_addr(r_best)
    );

    hmm_mod #(.BUCKETS(BUCKETS)) u_mod (
        .i_clk, .i_rst_n,
        .i_start(div_start), .i_mag(div_mag),
        .o_busy(div_busy), .o_rem(div_rem)
    );

    // magnitude of the candidate key; the minimum key maps to 2^31
    assign div_mag = r_ikey[DW-1] ? (DW'(0) - r_ikey) : r_ikey;
    assign age     = r_oc - rd_slot.pstamp;
    assign nage    = r_oc - r_ins;
    assign key_hit = rd_valid && (rd_slot.key == r_key);
    // tie order: more values, then lower bucket, then older node
    assign better  = !r_best_f || (r_icnt > r_bcnt) ||
                     ((r_icnt == r_bcnt) && ((div_rem < r_bbkt) ||
                      ((div_rem == r_bbkt) && (nage > r_best_age))));

    assign wr_slot = '{key: r_key, value: r_val, pstamp: r_oc,
                       nstamp: (r_own_f ? r_own_ns : r_oc)};

    always_comb begin
        n_state = r_state;     n_resume = r_resume;
        n_key = r_key;         n_val = r_val;
        n_oc = r_oc;           n_count = r_count;
        n_idx = r_idx;         n_jdx = r_jdx;
        n_free_f = r_free_f;   n_own_f = r_own_f;
        n_free = r_free;       n_own_ns = r_own_ns;
        n_best_f = r_best_f;   n_bound_en = r_bound_en;
        n_best = r_best;       n_best_age = r_best_age;
        n_bound = r_bound;     n_bval = r_bval;
        n_cand = r_cand;
        n_ikey = r_ikey;       n_ins = r_ins;      n_bkey = r_bkey;
        n_icnt = r_icnt;       n_bcnt = r_bcnt;    n_bbkt = r_bbkt;
        n_ovalid = r_ovalid;   n_olast = r_olast;
        n_status = r_status;   n_oval = r_oval;    n_okey = r_okey;
        rd_addr = r_idx;
        wr_en = 1'b0;  clr_en = 1'b0;  div_start = 1'b0;

        unique case (r_state)
            hmm_pkg::S_IDLE: begin
                n_idx = '0;  n_free_f = 1'b0;  n_own_f = 1'b0;
                n_best_f = 1'b0;  n_bound_en = 1'b0;  n_cand = '0;
                n_status = hmm_pkg::ST_OK;  n_oval = '0;  n_okey = '0;
                n_olast = 1'b1;  n_resume = hmm_pkg::S_IDLE;
                if (i_valid) begin
                    n_key = $unsigned(i_key);
                    n_val = $unsigned(i_value);
                    unique case (hmm_pkg::t_cmd'(i_command))
                        hmm_pkg::CMD_ADD:    n_state = hmm_pkg::S_ADD_RD;
                        hmm_pkg::CMD_LOOKUP: n_state = hmm_pkg::S_LK_RD;
                        hmm_pkg::CMD_REMOVE: n_state = hmm_pkg::S_RM_RD;
                        hmm_pkg::CMD_MOST: begin
                            if (r_count == '0) begin
                                n_status = hmm_pkg::ST_EMPTY;
                                n_ovalid = 1'b1;
                                n_state  = hmm_pkg::S_OUT;
                            end else begin
                                n_state = hmm_pkg::S_MF_RDI;
                            end
                        end
                        default: begin
                            n_ovalid = 1'b1;
                            n_state  = hmm_pkg::S_OUT;
                        end
                    endcase
                end
            end

            // add: first free slot and first slot owning the key
            hmm_pkg::S_ADD_RD: n_state = hmm_pkg::S_ADD_EV;
            hmm_pkg::S_ADD_EV: begin
                if (!rd_valid && !r_free_f) begin
                    n_free_f = 1'b1;  n_free = r_idx;
                end
                if (key_hit && !r_own_f) begin
                    n_own_f = 1'b1;  n_own_ns = rd_slot.nstamp;
                end
                n_idx = r_idx + 1'b1;
                n_state = (r_idx == IW'(ENTRIES - 1)) ? hmm_pkg::S_ADD_WR
                                                      : hmm_pkg::S_ADD_RD;
            end
            hmm_pkg::S_ADD_WR: begin
                if (r_free_f) begin
                    wr_en = 1'b1;
                    n_oc = r_oc + 1'b1;
                    n_count = r_count + 1'b1;
                end else begin
                    n_status = hmm_pkg::ST_FULL;
                end
                n_ovalid = 1'b1;
                n_state  = hmm_pkg::S_OUT;
            end

            // lookup: each pass picks the oldest pair younger than the last one
            hmm_pkg::S_LK_RD: n_state = hmm_pkg::S_LK_EV;
            hmm_pkg::S_LK_EV: begin
                if (key_hit && (!r_bound_en || (age < r_bound))) begin
                    n_cand = r_cand + 1'b1;
                    if (!r_best_f || (age > r_best_age)) begin
                        n_best_f = 1'b1;  n_best_age = age;
                        n_bval = rd_slot.value;
                    end
                end
                n_idx = r_idx + 1'b1;
                n_state = (r_idx == IW'(ENTRIES - 1)) ? hmm_pkg::S_LK_END
                                                      : hmm_pkg::S_LK_RD;
            end
            hmm_pkg::S_LK_END: begin
                if (r_cand == '0) begin
                    n_status = hmm_pkg::ST_NOT_FOUND;
                    n_oval = '0;
                    n_olast = 1'b1;
                    n_resume = hmm_pkg::S_IDLE;
                end else begin
                    n_oval = r_bval;
                    n_olast = (r_cand == CW'(1));
                    n_resume = (r_cand == CW'(1)) ? hmm_pkg::S_IDLE
                                                  : hmm_pkg::S_LK_RD;
                end
                n_bound = r_best_age;  n_bound_en = 1'b1;
                n_best_f = 1'b0;  n_cand = '0;  n_idx = '0;
                n_ovalid = 1'b1;
                n_state  = hmm_pkg::S_OUT;
            end

            // remove: oldest equal pair
            hmm_pkg::S_RM_RD: n_state = hmm_pkg::S_RM_EV;
            hmm_pkg::S_RM_EV: begin
                if (key_hit && (rd_slot.value == r_val) &&
                    (!r_best_f || (age > r_best_age))) begin
                    n_best_f = 1'b1;  n_best_age = age;  n_best = r_idx;
                end
                n_idx = r_idx + 1'b1;
                n_state = (r_idx == IW'(ENTRIES - 1)) ? hmm_pkg::S_RM_END
                                                      : hmm_pkg::S_RM_RD;
            end
            hmm_pkg::S_RM_END: begin
                if (r_best_f) begin
                    clr_en = 1'b1;
                    n_count = r_count - 1'b1;
                end else begin
                    n_status = hmm_pkg::ST_NOT_FOUND;
                end
                n_ovalid = 1'b1;
                n_state  = hmm_pkg::S_OUT;
            end

            // most frequent: outer slot, inner count, bucket, compare
            hmm_pkg::S_MF_RDI: n_state = hmm_pkg::S_MF_LATI;
            hmm_pkg::S_MF_LATI: begin
                if (rd_valid) begin
                    n_ikey = rd_slot.key;  n_ins = rd_slot.nstamp;
                    n_icnt = '0;  n_jdx = '0;
                    n_state = hmm_pkg::S_MF_RDJ;
                end else begin
                    n_idx = r_idx + 1'b1;
                    n_state = (r_idx == IW'(ENTRIES - 1)) ? hmm_pkg::S_MF_END
                                                          : hmm_pkg::S_MF_RDI;
                end
            end
            hmm_pkg::S_MF_RDJ: begin
                rd_addr = r_jdx;
                n_state = hmm_pkg::S_MF_EVJ;
            end
            hmm_pkg::S_MF_EVJ: begin
                if (rd_valid && (rd_slot.key == r_ikey)) n_icnt = r_icnt + 1'b1;
                n_jdx = r_jdx + 1'b1;
                if (r_jdx == IW'(ENTRIES - 1)) begin
                    div_start = 1'b1;
                    n_state = hmm_pkg::S_MF_DIV;
                end else begin
                    n_state = hmm_pkg::S_MF_RDJ;
                end
            end
            hmm_pkg::S_MF_DIV: if (!div_busy) n_state = hmm_pkg::S_MF_CMP;
            hmm_pkg::S_MF_CMP: begin
                if (better) begin
                    n_best_f = 1'b1;  n_bcnt = r_icnt;  n_bbkt = div_rem;
                    n_best_age = nage;  n_bkey = r_ikey;
                end
                n_idx = r_idx + 1'b1;
                n_state = (r_idx == IW'(ENTRIES - 1)) ? hmm_pkg::S_MF_END
                                                      : hmm_pkg::S_MF_RDI;
            end
            hmm_pkg::S_MF_END: begin
                n_okey = r_bkey;
                n_ovalid = 1'b1;
                n_state  = hmm_pkg::S_OUT;
            end

            // hold the result word until taken
            hmm_pkg::S_OUT: begin
                if (!i_stall) begin
                    n_ovalid = 1'b0;
                    n_state  = r_resume;
                end
            end
            default: n_state = hmm_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= hmm_pkg::S_IDLE;
            r_resume <= hmm_pkg::S_IDLE;
            r_oc     <= '0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_resume <= n_resume;
            r_oc     <= n_oc;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;  r_val <= n_val;
        r_idx <= n_idx;  r_jdx <= n_jdx;
        r_free_f <= n_free_f;  r_own_f <= n_own_f;
        r_free <= n_free;  r_own_ns <= n_own_ns;
        r_best_f <= n_best_f;  r_bound_en <= n_bound_en;
        r_best <= n_best;  r_best_age <= n_best_age;
        r_bound <= n_bound;  r_bval <= n_bval;  r_cand <= n_cand;
        r_ikey <= n_ikey;  r_ins <= n_ins;  r_bkey <= n_bkey;
        r_icnt <= n_icnt;  r_bcnt <= n_bcnt;  r_bbkt <= n_bbkt;
        r_olast <= n_olast;  r_status <= n_status;
        r_oval <= n_oval;  r_okey <= n_okey;
    end

    assign o_stall      = (r_state != hmm_pkg::S_IDLE);
    assign o_valid      = r_ovalid;
    assign o_status     = r_status;
    assign o_out_value  = $signed(r_oval);
    assign o_out_key    = $signed(r_okey);
    assign o_pair_total = hmm_pkg::TOTAL_W'(r_count);
    assign o_is_empty   = (r_count == '0);
    assign o_last       = r_olast;
endmodule
`default_nettype wire

FILE: rtl/hmm_store.sv
// ----------------------------------------------------------------------------
// hmm_store
// slot memory with registered read and per-slot valid flops
// ----------------------------------------------------------------------------
`default_nettype none
module hmm_store #(
    parameter int ENTRIES = hmm_pkg::ENTRIES_DEF,
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic [IW-1:0]  i_rd_addr,
    output hmm_pkg::t_slot      o_rd_slot,
    output logic                o_rd_valid,
    input  wire logic           i_wr_en,
    input  wire logic [IW-1:0]  i_wr_addr,
    input  wire hmm_pkg::t_slot i_wr_slot,
    input  wire logic           i_clr_en,
    input  wire logic [IW-1:0]  i_clr_addr
);
    hmm_pkg::t_slot   mem [ENTRIES];
    logic [ENTRIES-1:0] r_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_slot;
        end
        o_rd_slot <= mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            o_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) r_valid[i_wr_addr] <= 1'b1;
            if (i_clr_en) r_valid[i_clr_addr] <= 1'b0;
            o_rd_valid <= r_valid[i_rd_addr];
        end
    end
endmodule
`default_nettype wire

FILE: rtl/hmm_mod.sv
// ----------------------------------------------------------------------------
// hmm_mod
// remainder of a 32-bit magnitude by the bucket count, one byte per cycle
// ----------------------------------------------------------------------------
`default_nettype none
module hmm_mod #(
    parameter int BUCKETS = hmm_pkg::BUCKETS_DEF,
    localparam int BW = $clog2(BUCKETS + 1)
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [hmm_pkg::DATA_W-1:0] i_mag,
    output logic                            o_busy,
    output logic [BW-1:0]                   o_rem
);
    // partial remainder with the next byte appended, quotient by reciprocal
    localparam int TW = BW + 8;
    localparam int SH = 2 * BW + 9;
    localparam int RW = SH + 1;
    localparam int PW = TW + RW;
    localparam logic [RW-1:0] RECIP =
        RW'(((64'd1 << SH) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));

    logic [hmm_pkg::DATA_W-1:0] r_sh;
    logic [1:0]                 r_cnt;
    logic [TW-1:0]              part;
    logic [PW-1:0]              prod;
    logic [7:0]                 quot;
    logic [TW-1:0]              rem_nx;

    assign part   = {o_rem, r_sh[hmm_pkg::DATA_W-1 -: 8]};
    assign prod   = PW'(part) * PW'(RECIP);
    assign quot   = prod[SH +: 8];
    assign rem_nx = part - TW'(quot) * TW'(BUCKETS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_busy <= 1'b0;
        end else if (i_start) begin
            o_busy <= 1'b1;
            r_cnt  <= '0;
            r_sh   <= i_mag;
            o_rem  <= '0;
        end else if (o_busy) begin
            r_sh  <= {r_sh[hmm_pkg::DATA_W-9:0], 8'h00};
            r_cnt <= r_cnt + 1'b1;
            o_rem <= rem_nx[BW-1:0];
            if (r_cnt == 2'd3) o_busy <= 1'b0;
        end
    end
endmodule
`default_nettype wire

FILE: rtl/hmm_checker.sv
// ----------------------------------------------------------------------------
// hmm_checker
// port-level checks of the hash multimap
// ----------------------------------------------------------------------------
`default_nettype none
module hmm_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       o_stall,
    input wire logic       o_valid,
    input wire logic       i_stall,
    input wire logic [1:0] o_status,
    input wire logic [6:0] o_pair_total,
    input wire logic       o_is_empty,
    input wire logic       o_last
);
    // busy right after a command is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall) else $error("not busy after accept");

    // no new command while a result word waits
    a_hold_while_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall) else $error("ready with pending result");

    // a stalled result word holds
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_status) && $stable(o_last)))
        else $error("stalled result changed");

    // empty flag agrees with the pair total
    a_empty_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_is_empty == (o_pair_total == 7'd0)))
        else $error("empty flag mismatch");
endmodule

bind hash_multimap_with_top_key hmm_checker u_hmm_checker (
    .i_clk, .i_rst_n, .i_valid, .o_stall, .o_valid, .i_stall,
    .o_status, .o_pair_total, .o_is_empty, .o_last
);
`default_nettype wire

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the hash multimap: a behavioral copy of the map
// predicts every result word, random idling on both channels
// ----------------------------------------------------------------------------
`default_nettype none

// expected result words and the behavioral map that produces them
class mmap_scoreboard;
    typedef struct {
        logic [1:0]  status;
        logic [31:0] out_value;
        logic [31:0] out_key;
        logic [6:0]  pair_total;
        logic        is_empty;
        logic        last;
    } t_word;

    logic [31:0] key_q[64];
    logic [31:0] val_q[64];
    logic [31:0] pst_q[64];
    logic [31:0] nst_q[64];
    bit          used_q[64];
    logic [31:0] order_cnt;
    int          pairs;
    t_word       pending[$];
    int          errors;

    function new();
        foreach (used_q[i]) used_q[i] = 0;
        order_cnt = 0;
        pairs     = 0;
        errors    = 0;
    endfunction

    function void push(logic [1:0] st, logic [31:0] v, logic [31:0] k, bit lst);
        t_word w;
        w.status     = st;
        w.out_value  = v;
        w.out_key    = k;
        w.pair_total = pairs[6:0];
        w.is_empty   = (pairs == 0);
        w.last       = lst;
        pending.insert(pending.size(), w);
    endfunction

    function logic [31:0] bucket_of(logic [31:0] k);
        logic [31:0] mag;
        mag = k[31] ? (32'd0 - k) : k;
        return mag % 32'd101;
    endfunction

    // note one accepted command word and queue its results
    function void note_command(logic [2:0] cmd, logic [31:0] k, logic [31:0] v);
        int free_s, owner, best, n, s, j;
        int list[$];
        logic [31:0] cnt, bkt, age, b_cnt, b_bkt, b_age;
        bit better;
        free_s = -1; owner = -1; best = -1;
        case (cmd)
            hmm_pkg::CMD_ADD: begin
                for (int i = 0; i < 64; i++) begin
                    if (!used_q[i]) begin
                        if (free_s < 0) free_s = i;
                    end else if (key_q[i] == k && owner < 0) begin
                        owner = i;
                    end
                end
                if (free_s < 0) begin
                    push(hmm_pkg::ST_FULL, 0, 0, 1);
                end else begin
                    used_q[free_s] = 1;
                    key_q[free_s]  = k;
                    val_q[free_s]  = v;
                    pst_q[free_s]  = order_cnt;
                    nst_q[free_s]  = owner >= 0 ? nst_q[owner] : order_cnt;
                    order_cnt++;
                    pairs++;
                    push(hmm_pkg::ST_OK, 0, 0, 1);
                end
            end
            hmm_pkg::CMD_LOOKUP: begin
                for (int i = 0; i < 64; i++)
                    if (used_q[i] && key_q[i] == k) list.insert(list.size(), i);
                n = list.size();
                if (n == 0) begin
                    push(hmm_pkg::ST_NOT_FOUND, 0, 0, 1);
                end else begin
                    // oldest pair first
                    for (int i = 1; i < n; i++) begin
                        s = list[i];
                        j = i;
                        while (j > 0 && (order_cnt - pst_q[list[j-1]]) <
                                        (order_cnt - pst_q[s])) begin
                            list[j] = list[j-1];
                            j--;
                        end
                        list[j] = s;
                    end
                    for (int i = 0; i < n; i++)
                        push(hmm_pkg::ST_OK, val_q[list[i]], 0, i == n - 1);
                end
            end
            hmm_pkg::CMD_REMOVE: begin
                for (int i = 0; i < 64; i++)
                    if (used_q[i] && key_q[i] == k && val_q[i] == v)
                        if (best < 0 || (order_cnt - pst_q[i]) >
                                        (order_cnt - pst_q[best]))
                            best = i;
                if (best < 0) begin
                    push(hmm_pkg::ST_NOT_FOUND, 0, 0, 1);
                end else begin
                    used_q[best] = 0;
                    pairs--;
                    push(hmm_pkg::ST_OK, 0, 0, 1);
                end
            end
            hmm_pkg::CMD_MOST: begin
                b_cnt = 0; b_bkt = 0; b_age = 0;
                for (int i = 0; i < 64; i++) begin
                    if (!used_q[i]) continue;
                    cnt = 0;
                    for (int m = 0; m < 64; m++)
                        if (used_q[m] && key_q[m] == key_q[i]) cnt++;
                    bkt = bucket_of(key_q[i]);
                    age = order_cnt - nst_q[i];
                    if (best < 0)          better = 1;
                    else if (cnt != b_cnt) better = cnt > b_cnt;
                    else if (bkt != b_bkt) better = bkt < b_bkt;
                    else                   better = age > b_age;
                    if (better) begin
                        best = i; b_cnt = cnt; b_bkt = bkt; b_age = age;
                    end
                end
                if (best < 0) push(hmm_pkg::ST_EMPTY, 0, 0, 1);
                else          push(hmm_pkg::ST_OK, 0, key_q[best], 1);
            end
            default: push(hmm_pkg::ST_OK, 0, 0, 1);
        endcase
    endfunction

    // compare one accepted result word with the oldest expectation
    function void check_word(logic [1:0] st, logic [31:0] v, logic [31:0] k,
                             logic [6:0] tot, logic emp, logic lst);
        t_word w;
        if (pending.size() == 0) begin
            $display("%0t: result word with nothing expected", $realtime);
            errors++;
            return;
        end
        w = pending.pop_front();
        if (st !== w.status) begin
            $display("%0t: status exp %0d got %0d", $realtime, w.status, st);
            errors++;
        end
        if (v !== w.out_value) begin
            $display("%0t: out_value exp %h got %h", $realtime, w.out_value, v);
            errors++;
        end
        if (k !== w.out_key) begin
            $display("%0t: out_key exp %h got %h", $realtime, w.out_key, k);
            errors++;
        end
        if (tot !== w.pair_total) begin
            $display("%0t: pair_total exp %0d got %0d", $realtime, w.pair_total, tot);
            errors++;
        end
        if (emp !== w.is_empty) begin
            $display("%0t: is_empty exp %0d got %0d", $realtime, w.is_empty, emp);
            errors++;
        end
        if (lst !== w.last) begin
            $display("%0t: last exp %0d got %0d", $realtime, w.last, lst);
            errors++;
        end
    endfunction
endclass

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_stall;
    logic [2:0]  i_command = 0;
    logic signed [31:0] i_key = 0;
    logic signed [31:0] i_value = 0;
    logic        o_valid;
    logic        i_stall = 1;
    logic [1:0]  o_status;
    logic signed [31:0] o_out_value;
    logic signed [31:0] o_out_key;
    logic [6:0]  o_pair_total;
    logic        o_is_empty;
    logic        o_last;

    mmap_scoreboard board = new();
    bit          stim_done = 0;
    bit          calm = 0;     // stretch with no idling
    logic [31:0] key_pool[8];

    hash_multimap_with_top_key i_dut (.*);

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    // mostly short gaps, a few long ones
    function automatic int gap_len();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // present one command word and hold it until accepted
    task automatic send_word(logic [2:0] cmd, logic [31:0] k, logic [31:0] v);
        int g;
        g = gap_len();
        if (g != 0) begin
            i_valid <= 0;
            repeat (g) @(posedge i_clk);
        end
        i_valid   <= 1;
        i_command <= cmd;
        i_key     <= k;
        i_value   <= v;
        do @(posedge i_clk); while (o_stall);
        board.note_command(cmd, k, v);
    endtask

    // receiver side: random stall, check on acceptance
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall)
                board.check_word(o_status, o_out_value, o_out_key,
                                 o_pair_total, o_is_empty, o_last);
            i_stall <= calm ? 1'b0 : (gap_len() != 0);
        end
    end

    function automatic logic [31:0] pick_key();
        int r;
        r = $urandom_range(0, 9);
        if (r < 8) return key_pool[r];
        return $urandom();
    endfunction

    initial begin
        logic [31:0] k;
        int r;
        key_pool = '{32'd5, 32'd106, -32'sd5, 32'h8000_0000,
                     32'h7fff_ffff, 32'd0, 32'd101, 32'h8000_0001};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: empty map, extremes, ties, not found
        send_word(hmm_pkg::CMD_MOST, 0, 0);
        send_word(hmm_pkg::CMD_LOOKUP, 5, 0);
        send_word(hmm_pkg::CMD_REMOVE, 5, 1);
        send_word(hmm_pkg::CMD_ADD, 32'h8000_0000, 32'h8000_0000);
        send_word(hmm_pkg::CMD_ADD, 32'h7fff_ffff, 32'h7fff_ffff);
        send_word(hmm_pkg::CMD_ADD, 106, 1);
        send_word(hmm_pkg::CMD_ADD, 5, 2);
        send_word(hmm_pkg::CMD_ADD, 5, 2);
        send_word(hmm_pkg::CMD_ADD, 106, 3);
        send_word(hmm_pkg::CMD_MOST, 0, 0);
        send_word(hmm_pkg::CMD_LOOKUP, 5, 0);
        send_word(hmm_pkg::CMD_REMOVE, 5, 2);
        send_word(hmm_pkg::CMD_MOST, 0, 0);
        send_word(hmm_pkg::CMD_REMOVE, 106, 1);
        send_word(hmm_pkg::CMD_ADD, 106, 4);
        send_word(hmm_pkg::CMD_COUNT, 32'hffff_ffff, 32'hffff_ffff);
        send_word(3'd5, 0, 0);
        send_word(3'd7, 0, 0);
        send_word(3'd6, 0, 0);
        send_word(hmm_pkg::CMD_LOOKUP, 32'h8000_0000, 0);
        send_word(hmm_pkg::CMD_MOST, 0, 0);

        // fill to full, then a full add
        calm = 1;
        while (board.pairs < 64)
            send_word(hmm_pkg::CMD_ADD, key_pool[$urandom_range(0, 7)], $urandom());
        calm = 0;
        send_word(hmm_pkg::CMD_ADD, 1, 1);
        send_word(hmm_pkg::CMD_MOST, 0, 0);
        send_word(hmm_pkg::CMD_LOOKUP, key_pool[0], 0);

        // random part, kept small most of the time so lookups stay short
        for (int n = 0; n < 350; n++) begin
            if (n % 100 == 50) calm = 1;
            if (n % 100 == 70) calm = 0;
            r = $urandom_range(0, 99);
            k = pick_key();
            if (r < 35) begin
                if (board.pairs > 40 && $urandom_range(0, 3) != 0)
                    send_word(hmm_pkg::CMD_REMOVE, k, $urandom_range(0, 3));
                else
                    send_word(hmm_pkg::CMD_ADD, k,
                              $urandom_range(0, 4) == 0 ? $urandom() : $urandom_range(0, 3));
            end else if (r < 60) begin
                send_word(hmm_pkg::CMD_REMOVE, k, $urandom_range(0, 3));
            end else if (r < 75) begin
                send_word(hmm_pkg::CMD_LOOKUP, k, $urandom());
            end else if (r < 88) begin
                send_word(hmm_pkg::CMD_MOST, $urandom(), $urandom());
            end else begin
                send_word(3'($urandom_range(4, 7)), $urandom(), $urandom());
            end
        end
        i_valid <= 0;
        stim_done = 1;
    end

    // wait for the last word, then a short drain
    initial begin
        wait (stim_done);
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // watchdog
    initial begin
        #100ms;
        $display("tb: failure");
        $finish;
    end
endmodule
`default_nettype wire

FILE: sim.f
rtl/hmm_pkg.sv
rtl/hmm_store.sv
rtl/hmm_mod.sv
rtl/hash_multimap_with_top_key.sv
rtl/hmm_checker.sv
verif/tb_top.sv
